// ===== src/wsdf_pkg.sv =====
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_PING   = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_TOOBIG = 2'd3
    } kind_t;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;

    localparam int unsigned MAX_LEN_W = 63;
    localparam int unsigned REM_W     = 64;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 63'd2147483647;

endpackage

// ===== src/websocket_frame_deframer_top.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------
// input    | in_valid / in_ready   | rx_byte[7:0]
// output   | out_valid / out_ready | kind[1:0], has_data, data[7:0], frame_end
// config   | cfg_we                | cfg_wdata[62:0] (max_payload_len)
//
// One byte per clock is sustained while the output is not stalled. A request
// is taken into an input register, parsed by combinational logic and any
// result lands in the output register. The parser advances only when the
// output register is free or being drained; a stalled output holds one result
// and one pending byte before in_ready drops. rst_n clears all control state
// asynchronously and sets the length limit to its default.

module websocket_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        has_data,
    output logic [7:0]  data,
    output logic        frame_end,
    input  logic        cfg_we,
    input  logic [wsdf_pkg::MAX_LEN_W-1:0] cfg_wdata
);

    logic                              in_valid_reg;
    logic [7:0]                        in_byte_reg;
    logic                              advance;

    logic [wsdf_pkg::MAX_LEN_W-1:0]    max_len_reg;

    wsdf_pkg::phase_t                  phase_reg, phase_next;
    logic [3:0]                        opcode_reg, opcode_next;
    logic                              mask_present_reg, mask_present_next;
    logic [2:0]                        ext_left_reg, ext_left_next;
    logic [wsdf_pkg::REM_W-1:0]        remaining_reg, remaining_next;
    logic [31:0]                       mask_key_reg, mask_key_next;
    logic [1:0]                        mask_phase_reg, mask_phase_next;
    logic                              halted_reg, halted_next;

    logic                              out_valid_reg;
    wsdf_pkg::kind_t                   kind_reg;
    logic                              has_data_reg;
    logic [7:0]                        data_reg;
    logic                              frame_end_reg;

    logic                              emit;
    wsdf_pkg::kind_t                   emit_kind;
    logic                              emit_has_data;
    logic [7:0]                        emit_data;
    logic                              emit_end;

    logic                              len_done;
    logic                              hdr_done;
    logic [6:0]                        len7;
    logic [7:0]                        key_byte;
    logic                              last_byte;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= wsdf_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    assign len7      = in_byte_reg[6:0];
    assign last_byte = (remaining_reg == {{(wsdf_pkg::REM_W-1){1'b0}}, 1'b1});

    always_comb
    begin
        case (mask_phase_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        opcode_next       = opcode_reg;
        mask_present_next = mask_present_reg;
        ext_left_next     = ext_left_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        mask_phase_next   = mask_phase_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        emit_kind         = wsdf_pkg::KIND_TEXT;
        emit_has_data     = 1'b0;
        emit_data         = 8'd0;
        emit_end          = 1'b0;
        len_done          = 1'b0;
        hdr_done          = 1'b0;

        if (!halted_reg)
        begin
            case (phase_reg)
                wsdf_pkg::PH_HDR0:
                begin
                    opcode_next = in_byte_reg[3:0];
                    phase_next  = wsdf_pkg::PH_HDR1;
                end
                wsdf_pkg::PH_HDR1:
                begin
                    mask_present_next = in_byte_reg[7];
                    mask_key_next     = 32'd0;
                    if (len7 inside {wsdf_pkg::LEN7_EXT16, wsdf_pkg::LEN7_EXT64})
                    begin
                        remaining_next = '0;
                        ext_left_next  = (len7 == wsdf_pkg::LEN7_EXT16) ?
                                         wsdf_pkg::EXT16_LEFT : wsdf_pkg::EXT64_LEFT;
                        phase_next     = wsdf_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        remaining_next = {{(wsdf_pkg::REM_W-7){1'b0}}, len7};
                        len_done       = 1'b1;
                    end
                end
                wsdf_pkg::PH_EXTLEN:
                begin
                    remaining_next = {remaining_reg[wsdf_pkg::REM_W-9:0], in_byte_reg};
                    if (ext_left_reg != 3'd0)
                    begin
                        ext_left_next = ext_left_reg - 3'd1;
                    end
                    else
                    begin
                        len_done = 1'b1;
                    end
                end
                wsdf_pkg::PH_MASK:
                begin
                    mask_key_next = {mask_key_reg[23:0], in_byte_reg};
                    if (mask_phase_reg != 2'd3)
                    begin
                        mask_phase_next = mask_phase_reg + 2'd1;
                    end
                    else
                    begin
                        hdr_done = 1'b1;
                    end
                end
                wsdf_pkg::PH_PAYLOAD:
                begin
                    mask_phase_next = mask_phase_reg + 2'd1;
                    remaining_next  = remaining_reg - {{(wsdf_pkg::REM_W-1){1'b0}}, 1'b1};
                    if (last_byte)
                    begin
                        phase_next = wsdf_pkg::PH_HDR0;
                    end
                    emit_data     = mask_present_reg ? (in_byte_reg ^ key_byte) : in_byte_reg;
                    emit_has_data = 1'b1;
                    emit_end      = last_byte;
                    if (opcode_reg == wsdf_pkg::OP_TEXT)
                    begin
                        emit      = 1'b1;
                        emit_kind = wsdf_pkg::KIND_TEXT;
                    end
                    else if (opcode_reg == wsdf_pkg::OP_PING)
                    begin
                        emit      = 1'b1;
                        emit_kind = wsdf_pkg::KIND_PING;
                    end
                    else if (opcode_reg == wsdf_pkg::OP_CLOSE && last_byte)
                    begin
                        // Close payload is swallowed; only the event goes out.
                        emit          = 1'b1;
                        emit_kind     = wsdf_pkg::KIND_CLOSE;
                        emit_has_data = 1'b0;
                        emit_data     = 8'd0;
                        halted_next   = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = wsdf_pkg::PH_HDR0;
                end
            endcase

            if (len_done)
            begin
                if (mask_present_next)
                begin
                    mask_phase_next = 2'd0;
                    phase_next      = wsdf_pkg::PH_MASK;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // The header is complete: check the limit and settle the frame.
            if (hdr_done)
            begin
                mask_phase_next = 2'd0;
                if (remaining_next > {1'b0, max_len_reg})
                begin
                    halted_next = 1'b1;
                    emit        = 1'b1;
                    emit_kind   = wsdf_pkg::KIND_TOOBIG;
                    emit_end    = 1'b1;
                end
                else if (remaining_next != '0)
                begin
                    phase_next = wsdf_pkg::PH_PAYLOAD;
                end
                else
                begin
                    phase_next = wsdf_pkg::PH_HDR0;
                    emit_end   = 1'b1;
                    if (opcode_next == wsdf_pkg::OP_TEXT)
                    begin
                        emit      = 1'b1;
                        emit_kind = wsdf_pkg::KIND_TEXT;
                    end
                    else if (opcode_next == wsdf_pkg::OP_PING)
                    begin
                        emit      = 1'b1;
                        emit_kind = wsdf_pkg::KIND_PING;
                    end
                    else if (opcode_next == wsdf_pkg::OP_CLOSE)
                    begin
                        emit        = 1'b1;
                        emit_kind   = wsdf_pkg::KIND_CLOSE;
                        halted_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsdf_pkg::PH_HDR0;
            opcode_reg       <= 4'd0;
            mask_present_reg <= 1'b0;
            ext_left_reg     <= 3'd0;
            remaining_reg    <= '0;
            mask_key_reg     <= 32'd0;
            mask_phase_reg   <= 2'd0;
            halted_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            opcode_reg       <= opcode_next;
            mask_present_reg <= mask_present_next;
            ext_left_reg     <= ext_left_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            mask_phase_reg   <= mask_phase_next;
            halted_reg       <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg      <= emit_kind;
            has_data_reg  <= emit_has_data;
            data_reg      <= emit_data;
            frame_end_reg <= emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign has_data  = has_data_reg;
    assign data      = data_reg;
    assign frame_end = frame_end_reg;

endmodule
